### design/tlg_pkg.sv
// Shared constants, codes and controller/datapath interface types for the life grid engine.
`timescale 1ns / 1ps
`default_nettype none

package tlg_pkg;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;

   localparam int CFG_W       = 7;
   localparam int CFG_RESET   = 64;
   localparam int MODE_W      = 2;
   localparam int CELL_IDX_W  = 6;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam int MIN_SIZE    = 3;
   localparam int BIRTH_COUNT = 3;
   localparam int SURVIVE_LOW = 2;
   localparam int NEIGHBOURS  = 8;

   localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   typedef struct packed {
      logic accept;
      logic clr_step;
      logic rd_cell;
      logic wr_cell;
      logic cap_cell;
      logic row_reset;
      logic rd_up;
      logic rd_mid;
      logic rd_dn;
      logic wr_next;
      logic row_inc;
      logic flip_bank;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic              clr_last;
      logic              row_last;
      logic              req_in_range;
      logic [MODE_W-1:0] req_mode;
      logic              cur_is_write;
      logic              rsp_free;
   } status_type;

endpackage

`default_nettype wire

### design/tlg_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tlg_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/tlg_ctrl.sv
// Controller state machine that sequences clearing, cell accesses and generation advances.
`timescale 1ns / 1ps
`default_nettype none

module tlg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output tlg_pkg::cmd_type    cmd,
   input  tlg_pkg::status_type status
);
   import tlg_pkg::*;

   typedef enum logic [10:0] {
      ST_CLEAR    = 11'b000_0000_0001,
      ST_IDLE     = 11'b000_0000_0010,
      ST_CELL_RD  = 11'b000_0000_0100,
      ST_CELL_WR  = 11'b000_0000_1000,
      ST_CELL_CAP = 11'b000_0001_0000,
      ST_ADV_UP   = 11'b000_0010_0000,
      ST_ADV_MID  = 11'b000_0100_0000,
      ST_ADV_DN   = 11'b000_1000_0000,
      ST_ADV_CALC = 11'b001_0000_0000,
      ST_ADV_WR   = 11'b010_0000_0000,
      ST_RESP     = 11'b100_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               priority if (status.req_mode == MODE_ADVANCE) begin
                  cmd.row_reset = 1'b1;
                  state_in      = ST_ADV_UP;
               end else if ((status.req_mode == MODE_WRITE || status.req_mode == MODE_READ)
                            && status.req_in_range) begin
                  state_in = ST_CELL_RD;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_CELL_RD: begin
            cmd.rd_cell = 1'b1;
            state_in    = status.cur_is_write ? ST_CELL_WR : ST_CELL_CAP;
         end
         ST_CELL_WR: begin
            cmd.wr_cell = 1'b1;
            state_in    = ST_RESP;
         end
         ST_CELL_CAP: begin
            cmd.cap_cell = 1'b1;
            state_in     = ST_RESP;
         end
         ST_ADV_UP: begin
            cmd.rd_up = 1'b1;
            state_in  = ST_ADV_MID;
         end
         ST_ADV_MID: begin
            cmd.rd_mid = 1'b1;
            state_in   = ST_ADV_DN;
         end
         ST_ADV_DN: begin
            cmd.rd_dn = 1'b1;
            state_in  = ST_ADV_CALC;
         end
         ST_ADV_CALC: begin
            state_in = ST_ADV_WR;
         end
         ST_ADV_WR: begin
            cmd.wr_next = 1'b1;
            if (status.row_last) begin
               cmd.flip_bank = 1'b1;
               state_in      = ST_RESP;
            end else begin
               cmd.row_inc = 1'b1;
               state_in    = ST_ADV_UP;
            end
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_step, cmd.wr_cell, cmd.wr_next}))
      else $error("More than one source drives the grid memory write port.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("A new transaction was accepted while one was still in progress.");
`endif

endmodule

`default_nettype wire

### design/tlg_datapath.sv
// Datapath holding the registers, grid memory, row buffers and next-generation logic.
`timescale 1ns / 1ps
`default_nettype none

module tlg_datapath #(
   parameter int MAX_ROWS = tlg_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = tlg_pkg::DEF_MAX_COLS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [tlg_pkg::MODE_W-1:0]       req_mode,
   input  logic [tlg_pkg::CELL_IDX_W-1:0]   req_cell_row,
   input  logic [tlg_pkg::CELL_IDX_W-1:0]   req_cell_col,
   input  logic                             req_alive_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_alive_out,
   output logic                             rsp_range_error,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tlg_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tlg_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tlg_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   input  tlg_pkg::cmd_type                 cmd,
   output tlg_pkg::status_type              status
);
   import tlg_pkg::*;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int NR_W   = $clog2(MAX_ROWS + 1);
   localparam int NC_W   = $clog2(MAX_COLS + 1);
   localparam int ADDR_W = ROW_W + 1;
   localparam int DEPTH  = 2 ** ADDR_W;
   localparam int CNT_W  = $clog2(NEIGHBOURS + 1);

   logic [CFG_W-1:0]    rows_ff, rows_in, cols_ff, cols_in;
   logic                bank_ff, bank_in;
   logic [ROW_W-1:0]    row_cnt_ff, row_cnt_in;
   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic                cap_up_ff, cap_mid_ff, cap_dn_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [MODE_W-1:0]   mode_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [COL_W-1:0]    col_ff;
   logic                alive_ff;
   logic                in_range_ff;
   logic                cell_bit_ff;
   logic                rsp_alive_ff, rsp_err_ff;
   logic [MAX_COLS-1:0] up_ff, mid_ff, dn_ff;

   logic                csr_wr;
   logic [NR_W-1:0]     nr;
   logic [NC_W-1:0]     nc;
   logic [COL_W-1:0]    ncm1;
   logic                req_in_range;
   logic [ROW_W-1:0]    r_up, r_dn;
   logic                row_keep;
   logic                up_last, mid_last, dn_last;
   logic [MAX_COLS-1:0] next_row;
   logic [MAX_COLS-1:0] cell_row_data;

   logic                ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [MAX_COLS-1:0] ram_wr_data, ram_rd_data;

   // Configuration registers.
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_COLS) ? CSR_DATA_W'(cols_ff) : CSR_DATA_W'(rows_ff);

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_ROWS: rows_in = csr_pwdata[CFG_W-1:0];
            REG_COLS: cols_in = csr_pwdata[CFG_W-1:0];
         endcase
      end
   end

   // Effective grid size, clamped to the minimum and to the storage.
   always_comb begin
      priority if (rows_ff < CFG_W'(MIN_SIZE)) begin
         nr = NR_W'(MIN_SIZE);
      end else if (32'(rows_ff) > 32'(MAX_ROWS)) begin
         nr = NR_W'(MAX_ROWS);
      end else begin
         nr = NR_W'(rows_ff);
      end
      priority if (cols_ff < CFG_W'(MIN_SIZE)) begin
         nc = NC_W'(MIN_SIZE);
      end else if (32'(cols_ff) > 32'(MAX_COLS)) begin
         nc = NC_W'(MAX_COLS);
      end else begin
         nc = NC_W'(cols_ff);
      end
   end

   assign req_in_range = (32'(req_cell_row) < 32'(nr)) && (32'(req_cell_col) < 32'(nc));

   // Wrapped row indices around the row being computed.
   assign r_up     = (row_cnt_ff == '0) ? ROW_W'(nr - 1'b1) : row_cnt_ff - 1'b1;
   assign r_dn     = (32'(row_cnt_ff) + 32'd1 >= 32'(nr)) ? '0 : row_cnt_ff + 1'b1;
   assign row_keep = 32'(row_cnt_ff) >= 32'(nr);
   assign ncm1     = COL_W'(nc - 1'b1);
   assign up_last  = up_ff[ncm1];
   assign mid_last = mid_ff[ncm1];
   assign dn_last  = dn_ff[ncm1];

   for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
      logic             ul, ur, ml, mr, dl, dr;
      logic [CNT_W-1:0] cnt;
      logic             keep;

      if (c == 0) begin : g_left_wrap
         assign ul = up_last;
         assign ml = mid_last;
         assign dl = dn_last;
      end else begin : g_left
         assign ul = up_ff[c-1];
         assign ml = mid_ff[c-1];
         assign dl = dn_ff[c-1];
      end

      if (c == MAX_COLS - 1) begin : g_right_wrap
         assign ur = up_ff[0];
         assign mr = mid_ff[0];
         assign dr = dn_ff[0];
      end else begin : g_right
         logic wrap;
         assign wrap = (ncm1 == COL_W'(c));
         assign ur   = wrap ? up_ff[0]  : up_ff[c+1];
         assign mr   = wrap ? mid_ff[0] : mid_ff[c+1];
         assign dr   = wrap ? dn_ff[0]  : dn_ff[c+1];
      end

      assign cnt = CNT_W'(ul) + CNT_W'(up_ff[c]) + CNT_W'(ur) + CNT_W'(ml) + CNT_W'(mr)
                 + CNT_W'(dl) + CNT_W'(dn_ff[c]) + CNT_W'(dr);
      assign keep = row_keep || (32'(c) >= 32'(nc));
      assign next_row[c] = keep ? mid_ff[c]
                         : mid_ff[c] ? (cnt == CNT_W'(SURVIVE_LOW) || cnt == CNT_W'(BIRTH_COUNT))
                         : (cnt == CNT_W'(BIRTH_COUNT));
   end

   always_comb begin
      cell_row_data         = ram_rd_data;
      cell_row_data[col_ff] = alive_ff;
   end

   // Memory port selection.
   always_comb begin
      ram_rd_en   = cmd.rd_cell | cmd.rd_up | cmd.rd_mid | cmd.rd_dn;
      priority if (cmd.rd_up) begin
         ram_rd_addr = {bank_ff, r_up};
      end else if (cmd.rd_mid) begin
         ram_rd_addr = {bank_ff, row_cnt_ff};
      end else if (cmd.rd_dn) begin
         ram_rd_addr = {bank_ff, r_dn};
      end else begin
         ram_rd_addr = {bank_ff, row_ff};
      end

      ram_wr_en = cmd.clr_step | cmd.wr_cell | cmd.wr_next;
      priority if (cmd.clr_step) begin
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else if (cmd.wr_cell) begin
         ram_wr_addr = {bank_ff, row_ff};
         ram_wr_data = cell_row_data;
      end else begin
         ram_wr_addr = {~bank_ff, row_cnt_ff};
         ram_wr_data = next_row;
      end
   end

   tlg_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (DEPTH)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Control register next values.
   always_comb begin
      bank_in      = cmd.flip_bank ? ~bank_ff : bank_ff;
      row_cnt_in   = row_cnt_ff;
      if (cmd.row_reset) begin
         row_cnt_in = '0;
      end else if (cmd.row_inc) begin
         row_cnt_in = row_cnt_ff + 1'b1;
      end
      clr_cnt_in   = cmd.clr_step ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= CFG_W'(CFG_RESET);
         cols_ff      <= CFG_W'(CFG_RESET);
         bank_ff      <= 1'b0;
         row_cnt_ff   <= '0;
         clr_cnt_ff   <= '0;
         cap_up_ff    <= 1'b0;
         cap_mid_ff   <= 1'b0;
         cap_dn_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         bank_ff      <= bank_in;
         row_cnt_ff   <= row_cnt_in;
         clr_cnt_ff   <= clr_cnt_in;
         cap_up_ff    <= cmd.rd_up;
         cap_mid_ff   <= cmd.rd_mid;
         cap_dn_ff    <= cmd.rd_dn;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff     <= req_mode;
         row_ff      <= ROW_W'(32'(req_cell_row));
         col_ff      <= COL_W'(32'(req_cell_col));
         alive_ff    <= req_alive_in;
         in_range_ff <= req_in_range;
      end
      if (cmd.cap_cell) begin
         cell_bit_ff <= ram_rd_data[col_ff];
      end
      if (cap_up_ff) begin
         up_ff <= ram_rd_data;
      end
      if (cap_mid_ff) begin
         mid_ff <= ram_rd_data;
      end
      if (cap_dn_ff) begin
         dn_ff <= ram_rd_data;
      end
      if (cmd.load_rsp) begin
         rsp_alive_ff <= cell_bit_ff && (mode_ff == MODE_READ) && in_range_ff;
         rsp_err_ff   <= !in_range_ff && (mode_ff == MODE_WRITE || mode_ff == MODE_READ);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_alive_out   = rsp_alive_ff;
   assign rsp_range_error = rsp_err_ff;

   always_comb begin
      status              = '0;
      status.clr_last     = &clr_cnt_ff;
      status.row_last     = (row_cnt_ff == ROW_W'(MAX_ROWS - 1));
      status.req_in_range = req_in_range;
      status.req_mode     = req_mode;
      status.cur_is_write = (mode_ff == MODE_WRITE);
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

`ifndef NO_ASSERTIONS
   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_alive_ff && rsp_err_ff))
      else $error("A result reports a live cell together with a range error.");

   a_flip_at_last_row: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (bank_ff != $past(bank_ff))) |-> $past(cmd.wr_next && status.row_last))
      else $error("The current bank changed before the last row was written.");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_cell |-> in_range_ff && (mode_ff == MODE_WRITE))
      else $error("A cell write was issued for a transaction that must not write.");
`endif

endmodule

`default_nettype wire

### design/toroidal_life_grid_engine.sv
// Top level of the toroidal B3/S23 life grid engine.
`timescale 1ns / 1ps
`default_nettype none

// The engine holds a toroidal grid of one-bit cells, stored one row per memory word in two
// banks, and takes one transaction at a time. After reset a clearing pass writes every row of
// both banks, during which no transaction is accepted; register writes are taken throughout.
// A cell read or write in range passes through a memory read state and then a write or
// capture state before its result is loaded; an out-of-range access or an unused mode goes
// straight to the result state. An advance visits every row: each row needs three reads of
// the single memory read port (the row above, the row itself and the row below) before the
// whole new row is computed in one step and written to the other bank.
// The next transaction is accepted in the cycle after a result has been placed in the output
// register, whether or not that result has yet been taken.
module toroidal_life_grid_engine #(
   parameter int MAX_ROWS = tlg_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = tlg_pkg::DEF_MAX_COLS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tlg_pkg::MODE_W-1:0]     req_mode,
   input  logic [tlg_pkg::CELL_IDX_W-1:0] req_cell_row,
   input  logic [tlg_pkg::CELL_IDX_W-1:0] req_cell_col,
   input  logic                           req_alive_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_alive_out,
   output logic                           rsp_range_error,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tlg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tlg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tlg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import tlg_pkg::*;

   cmd_type    cmd;
   status_type status;

   tlg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   tlg_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_cell_row    (req_cell_row),
      .req_cell_col    (req_cell_col),
      .req_alive_in    (req_alive_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_alive_out   (rsp_alive_out),
      .rsp_range_error (rsp_range_error),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

`default_nettype wire
